/* design/i2a_pkg.sv */
// ---------------------------------------------------------------------------
// i2a_pkg
// Shared types for the integer to ASCII formatter: format codes and the
// character run handed from the formatter to the output stage.
// ---------------------------------------------------------------------------
package i2a_pkg;

  localparam int unsigned RunLen   = 8;
  localparam int unsigned CharW    = 7;
  localparam int unsigned FuncW    = 2;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned RunIdxW  = $clog2(RunLen);

  typedef enum logic [FuncW-1:0] {
    FMT_DEC5 = 2'd0,
    FMT_DEC2 = 2'd1,
    FMT_BIN8 = 2'd2,
    FMT_HEX4 = 2'd3
  } fmt_e;

  // chars[0] leaves first; last_idx is the slot of the final character
  typedef struct packed {
    logic [RunLen-1:0][CharW-1:0] chars;
    logic [RunIdxW-1:0]           last_idx;
  } i2a_run_t;

endpackage

/* design/i2a_conv.sv */
// ---------------------------------------------------------------------------
// i2a_conv
// Single-pass formatter: turns one format code and value into the full
// character run, most significant character in slot 0.
// ---------------------------------------------------------------------------
module i2a_conv (
  input  logic [i2a_pkg::FuncW-1:0]  func_i,
  input  logic [i2a_pkg::ValueW-1:0] value_i,
  output i2a_pkg::i2a_run_t          run_o
);

  localparam logic [i2a_pkg::CharW-1:0] CharZero   = 7'h30;
  localparam logic [i2a_pkg::CharW-1:0] CharUpperA = 7'h41;

  // one decimal digit: largest k with k*place <= rem, and what is left
  function automatic logic [19:0] dec_step(input logic [15:0] rem,
                                           input logic [16:0] place);
    logic [3:0]  dig;
    logic [15:0] sub;
    logic [16:0] mult;
    dig  = '0;
    sub  = '0;
    mult = '0;
    for (int k = 1; k <= 9; k++) begin
      mult = 17'(k) * place;
      if ({1'b0, rem} >= mult) begin
        dig = 4'(k);
        sub = mult[15:0];
      end
    end
    return {dig, rem - sub};
  endfunction

  function automatic logic [i2a_pkg::CharW-1:0] hex_char(input logic [3:0] nib);
    if (nib > 4'd9) begin
      return CharUpperA + i2a_pkg::CharW'(nib) - 7'd10;
    end
    return CharZero + i2a_pkg::CharW'(nib);
  endfunction

  logic [7:0]  lo;
  logic [19:0] s4, s3, s2, s1;
  logic [15:0] prod;
  logic [4:0]  q10;
  logic [7:0]  q10x10;
  logic [7:0]  r10;

  assign lo = value_i[7:0];

  // five digits by successive place values
  assign s4 = dec_step(value_i,    17'd10000);
  assign s3 = dec_step(s4[15:0],   17'd1000);
  assign s2 = dec_step(s3[15:0],   17'd100);
  assign s1 = dec_step(s2[15:0],   17'd10);

  // byte / 10 by reciprocal, exact below 1024; quotient up to 25
  assign prod   = 16'(lo) * 16'd205;
  assign q10    = prod[15:11];
  assign q10x10 = {q10, 3'b000} + {2'b00, q10, 1'b0};
  assign r10    = lo - q10x10;

  always_comb begin
    run_o = '0;
    unique case (i2a_pkg::fmt_e'(func_i))
      i2a_pkg::FMT_DEC5: begin
        run_o.chars[0] = CharZero + i2a_pkg::CharW'(s4[19:16]);
        run_o.chars[1] = CharZero + i2a_pkg::CharW'(s3[19:16]);
        run_o.chars[2] = CharZero + i2a_pkg::CharW'(s2[19:16]);
        run_o.chars[3] = CharZero + i2a_pkg::CharW'(s1[19:16]);
        run_o.chars[4] = CharZero + i2a_pkg::CharW'(s1[3:0]);
        run_o.last_idx = i2a_pkg::RunIdxW'(4);
      end
      i2a_pkg::FMT_DEC2: begin
        // values above 99 run past '9' in the first character
        run_o.chars[0] = CharZero + i2a_pkg::CharW'(q10);
        run_o.chars[1] = CharZero + i2a_pkg::CharW'(r10[3:0]);
        run_o.last_idx = i2a_pkg::RunIdxW'(1);
      end
      i2a_pkg::FMT_BIN8: begin
        for (int i = 0; i < 8; i++) begin
          run_o.chars[i] = CharZero + i2a_pkg::CharW'(lo[7-i]);
        end
        run_o.last_idx = i2a_pkg::RunIdxW'(7);
      end
      i2a_pkg::FMT_HEX4: begin
        run_o.chars[0] = hex_char(value_i[15:12]);
        run_o.chars[1] = hex_char(value_i[11:8]);
        run_o.chars[2] = hex_char(value_i[7:4]);
        run_o.chars[3] = hex_char(value_i[3:0]);
        run_o.last_idx = i2a_pkg::RunIdxW'(3);
      end
      default: begin
        run_o = '0;
      end
    endcase
  end

endmodule

/* design/integer_to_ascii_formatter_core.sv */
// ---------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats a 16-bit unsigned value as decimal or hex ASCII characters, or its
// low byte as two-digit decimal or binary, most significant first, last one flagged.
// ---------------------------------------------------------------------------
// Usage:
//   Slave channel: one request per number, tuser = format code, tdata = value.
//   Master channel: one request per character, tdata = ASCII code,
//   tlast on the final character of the number.
//   Characters per number: 5 (decimal), 2 (two-digit), 8 (binary), 4 (hex).
//   A request passes the input register, then the run register, before its
//   first character is offered on the master channel.
//   Throughput: one character per cycle while m_axis_tready is high. A
//   one-entry input register lets the next number wait while the current
//   run drains, so runs follow each other without a gap.
//   The formatter is a single combinational pass between the input register
//   and the run register; the run shifts out through the run register.
//   Reset empties both registers; nothing is in flight afterwards.
//   A stall on m_axis_tready holds the current character; the slave side
//   stays ready until the input register is occupied.
// ---------------------------------------------------------------------------
module integer_to_ascii_formatter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] ascii_char, [7] zero
  output logic        m_axis_tlast
);

  logic                              in_valid_q, in_valid_d;
  logic [i2a_pkg::FuncW-1:0]         func_q;
  logic [i2a_pkg::ValueW-1:0]        value_q;

  logic                              run_valid_q, run_valid_d;
  logic [i2a_pkg::RunLen-1:0][i2a_pkg::CharW-1:0] chars_q, chars_d;
  logic [i2a_pkg::RunIdxW-1:0]       cnt_q, cnt_d;

  i2a_pkg::i2a_run_t                 conv_run;

  logic s_acc, m_acc, run_done, run_free, load;

  i2a_conv u_conv (
    .func_i  (func_q),
    .value_i (value_q),
    .run_o   (conv_run)
  );

  assign s_axis_tready = ~in_valid_q;
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign m_acc         = m_axis_tvalid & m_axis_tready;
  assign run_done      = m_acc & m_axis_tlast;
  assign run_free      = ~run_valid_q | run_done;
  assign load          = in_valid_q & run_free;

  assign m_axis_tvalid = run_valid_q;
  assign m_axis_tdata  = {1'b0, chars_q[0]};
  assign m_axis_tlast  = (cnt_q == '0);

  always_comb begin
    in_valid_d = in_valid_q;
    if (load) begin
      in_valid_d = 1'b0;
    end else if (s_acc) begin
      in_valid_d = 1'b1;
    end
  end

  always_comb begin
    run_valid_d = run_valid_q;
    chars_d     = chars_q;
    cnt_d       = cnt_q;
    priority if (load) begin
      run_valid_d = 1'b1;
      chars_d     = conv_run.chars;
      cnt_d       = conv_run.last_idx;
    end else if (run_done) begin
      run_valid_d = 1'b0;
    end else if (m_acc) begin
      for (int i = 0; i < int'(i2a_pkg::RunLen) - 1; i++) begin
        chars_d[i] = chars_q[i+1];
      end
      cnt_d = cnt_q - 1'b1;
    end else begin
      // idle or stalled: run holds
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      run_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      run_valid_q <= run_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      func_q  <= s_axis_tuser;
      value_q <= s_axis_tdata;
    end
    chars_q <= chars_d;
    cnt_q   <= cnt_d;
  end

endmodule

/* design/i2a_checker.sv */
// ---------------------------------------------------------------------------
// i2a_checker
// Port-level checks for the integer to ASCII formatter, bound to the core.
// ---------------------------------------------------------------------------
module i2a_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tlast
);

  // stalled character holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled character changed");

  // single input register: full after a request is taken
  a_in_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input register took a second request");

  // nothing waiting when the run ends means the output goes idle
  a_run_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast && s_axis_tready |=>
      !m_axis_tvalid)
    else $error("character appeared with no number pending");

  // request into an idle block shows its first character after the input and run registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |-> ##2 m_axis_tvalid)
    else $error("first character late");

endmodule

bind integer_to_ascii_formatter_core i2a_checker u_i2a_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
